// ----- hdl/csme_pkg.sv -----
// package for the circuit successor move engine
// node count, index widths, operation and result kind codes, sequencer states
package csme_pkg;
   localparam int NODES = 16;
   localparam int IW = 4;
   localparam int CW = 5;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0, OP_MOVE = 2'd1, OP_INIT_BEGIN = 2'd2, OP_INIT_STEP = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_MOVE_WRITE = 2'd0, KIND_MOVE_REJECT = 2'd1,
      KIND_INIT_WRITE = 2'd2, KIND_INIT_READY = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MV_OLD, ST_MV_K, ST_MV_L, ST_MV_OUT1, ST_MV_OUT2,
      ST_IB_MARK, ST_IB_COLLECT, ST_IB_SWAP, ST_IS_FOLLOW, ST_IS_EMIT
   } state_type;
endpackage

// ----- hdl/circuit_successor_move_engine_core.sv -----
// circuit successor move engine, top level: table, sequencer and result port
// depends on csme_pkg
//
// usage: a command is taken at a clock edge where start is high and busy low.
// load writes the table at that edge and gives no result, busy stays low. a
// move reads the table three times through one shared read path and gives
// three write beats, or one reject beat if a touched node is fixed. init begin
// marks the targets of fixed nodes, then collects the free targets and gives a
// ready beat. an init step follows fixed chains one hop a cycle (up to 16
// hops) and gives a write beat; with the step position zero or past the free
// count it gives no beat and busy stays low. every result is shown for one
// cycle with rsp_valid; the receiver cannot stall, so nothing is held back.
// busy drops in the cycle that shows the final beat, so the next command can
// be taken at the edge ending it.
// reset clears fixed marks, free count, step position, current node and
// node_offset; successor and free order entries are undefined until written.
// node_offset is written on the csr channel, always ready, and must only be
// written while busy is low.
module circuit_successor_move_engine_core
   import csme_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_op,
   input  logic [3:0]        req_entry_index,
   input  logic [3:0]        req_entry_next,
   input  logic              req_entry_fixed,
   input  logic [3:0]        req_draw_a,
   input  logic [3:0]        req_draw_b,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic signed [7:0] csr_data,
   output logic              rsp_valid,
   output logic [1:0]        rsp_kind,
   output logic [3:0]        rsp_var_index,
   output logic signed [8:0] rsp_next_node,
   output logic [4:0]        rsp_steps_left,
   output logic              rsp_last
);
   logic [IW-1:0] succ_ff [NODES];
   logic [NODES-1:0] fixed_ff, taken_ff;
   logic [IW-1:0] order_ff [NODES];
   logic [CW-1:0] count_ff, pos_ff;
   logic [IW-1:0] cur_ff;
   logic signed [7:0] offset_ff;
   state_type state_ff, state_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [IW-1:0] a_ff, a_in, b_ff, b_in, old_ff, old_in;
   logic [IW-1:0] rd_addr, rd_data;
   logic [IW-1:0] draw_ff;
   logic [1:0] r_kind;
   logic [IW-1:0] r_var, r_nxt;
   logic [CW-1:0] r_steps;
   logic r_valid, r_last, r_zero;
   logic [IW-1:0] lo, hi, nn;
   logic [CW-1:0] nrank;

   // single shared table read port
   assign rd_data = succ_ff[rd_addr];
   assign csr_ready = 1'b1;
   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      lo = (a_ff < rd_data) ? a_ff : rd_data;
      hi = (a_ff < rd_data) ? rd_data : a_ff;
      nrank = (b_ff > IW'(NODES-3)) ? CW'(NODES-3) : {1'b0, b_ff};
      if (nrank >= {1'b0, lo}) begin
         nrank = nrank + 1'b1;
         if (nrank >= {1'b0, hi}) nrank = nrank + 1'b1;
      end
      nn = nrank[IW-1:0];
   end

   always_comb begin
      state_in = state_ff;
      scan_in = scan_ff;
      a_in = a_ff;
      b_in = b_ff;
      old_in = old_ff;
      rd_addr = a_ff;
      r_valid = 1'b0;
      r_kind = KIND_MOVE_WRITE;
      r_var = '0;
      r_nxt = '0;
      r_zero = 1'b0;
      r_steps = '0;
      r_last = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (op_type'(req_op))
                  OP_LOAD: state_in = ST_IDLE;
                  OP_MOVE: begin
                     a_in = req_draw_a;
                     b_in = req_draw_b;
                     state_in = ST_MV_OLD;
                  end
                  OP_INIT_BEGIN: begin
                     scan_in = '0;
                     state_in = ST_IB_MARK;
                  end
                  OP_INIT_STEP: begin
                     scan_in = '0;
                     if (pos_ff != '0 && pos_ff <= count_ff) state_in = ST_IS_FOLLOW;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_MV_OLD: begin
            rd_addr = a_ff;
            old_in = rd_data;
            b_in = nn;
            state_in = ST_MV_K;
         end
         ST_MV_K: begin
            rd_addr = old_ff;
            if (fixed_ff[a_ff] || fixed_ff[old_ff] || fixed_ff[b_ff]) begin
               r_valid = 1'b1;
               r_kind = KIND_MOVE_REJECT;
               r_var = a_ff;
               r_zero = 1'b1;
               r_last = 1'b1;
               state_in = ST_IDLE;
            end else begin
               r_valid = 1'b1;
               r_var = a_ff;
               r_nxt = rd_data;
               state_in = ST_MV_L;
            end
         end
         ST_MV_L: begin
            rd_addr = b_ff;
            r_valid = 1'b1;
            r_var = old_ff;
            r_nxt = rd_data;
            state_in = ST_MV_OUT2;
         end
         ST_MV_OUT2: begin
            r_valid = 1'b1;
            r_var = b_ff;
            r_nxt = old_ff;
            r_last = 1'b1;
            state_in = ST_IDLE;
         end
         ST_IB_MARK: begin
            rd_addr = scan_ff[IW-1:0];
            scan_in = scan_ff + 1'b1;
            if (scan_ff == CW'(NODES-1)) begin
               scan_in = '0;
               state_in = ST_IB_COLLECT;
            end
         end
         ST_IB_COLLECT: begin
            scan_in = scan_ff + 1'b1;
            if (scan_ff == CW'(NODES-1)) state_in = ST_IB_SWAP;
         end
         ST_IB_SWAP: begin
            r_valid = 1'b1;
            r_kind = KIND_INIT_READY;
            r_zero = 1'b1;
            r_steps = count_ff;
            r_last = 1'b1;
            state_in = ST_IDLE;
         end
         ST_IS_FOLLOW: begin
            rd_addr = cur_ff;
            scan_in = scan_ff + 1'b1;
            if (!fixed_ff[cur_ff] || scan_ff == CW'(NODES-1)) state_in = ST_IS_EMIT;
         end
         ST_IS_EMIT: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // init step swap position and emit values
   logic [CW-1:0] swap_k;
   logic [IW-1:0] step_nxt;
   always_comb begin
      if ({1'b0, draw_ff} < pos_ff) swap_k = pos_ff;
      else if ({1'b0, draw_ff} > count_ff - 1'b1) swap_k = count_ff - 1'b1;
      else swap_k = {1'b0, draw_ff};
      step_nxt = (pos_ff < count_ff) ? order_ff[swap_k[IW-1:0]] : order_ff[0];
   end

   // start pick for init begin
   logic [CW-1:0] pick;
   always_comb begin
      pick = ({1'b0, draw_ff} > count_ff - 1'b1) ? count_ff - 1'b1 : {1'b0, draw_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fixed_ff <= '0;
         count_ff <= '0;
         pos_ff <= '0;
         cur_ff <= '0;
         offset_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid <= r_valid || (state_ff == ST_IS_EMIT);
         if (csr_valid && csr_ready) offset_ff <= csr_data;
         if (state_ff == ST_IDLE && start && op_type'(req_op) == OP_LOAD)
            fixed_ff[req_entry_index] <= req_entry_fixed;
         if (state_ff == ST_IB_COLLECT) begin
            if (!taken_ff[scan_ff[IW-1:0]])
               count_ff <= ((scan_ff == '0) ? CW'(0) : count_ff) + 1'b1;
            else if (scan_ff == '0) count_ff <= '0;
         end
         if (state_ff == ST_IB_SWAP) begin
            if (count_ff == '0) pos_ff <= '0;
            else begin
               pos_ff <= CW'(1);
               cur_ff <= order_ff[pick[IW-1:0]];
            end
         end
         if (state_ff == ST_IS_FOLLOW && fixed_ff[cur_ff]) cur_ff <= rd_data;
         if (state_ff == ST_IS_EMIT) begin
            cur_ff <= step_nxt;
            pos_ff <= (pos_ff < count_ff) ? pos_ff + 1'b1 : CW'(0);
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      a_ff <= a_in;
      b_ff <= b_in;
      old_ff <= old_in;
      if (state_ff == ST_IDLE && start) draw_ff <= req_draw_a;
      if (state_ff == ST_IDLE && start && op_type'(req_op) == OP_LOAD)
         succ_ff[req_entry_index] <= req_entry_next;
      if (state_ff == ST_IB_MARK) begin
         if (scan_ff == '0) taken_ff <= fixed_ff[0] ? (NODES'(1) << rd_data) : '0;
         else if (fixed_ff[scan_ff[IW-1:0]]) taken_ff[rd_data] <= 1'b1;
      end
      if (state_ff == ST_IB_COLLECT && !taken_ff[scan_ff[IW-1:0]])
         order_ff[(scan_ff == '0) ? IW'(0) : count_ff[IW-1:0]] <= scan_ff[IW-1:0];
      if (state_ff == ST_IB_SWAP && count_ff != '0 && pick[IW-1:0] != '0) begin
         order_ff[0] <= order_ff[pick[IW-1:0]];
         order_ff[pick[IW-1:0]] <= order_ff[0];
      end
      if (state_ff == ST_IS_EMIT && pos_ff < count_ff && swap_k != pos_ff) begin
         order_ff[pos_ff[IW-1:0]] <= order_ff[swap_k[IW-1:0]];
         order_ff[swap_k[IW-1:0]] <= order_ff[pos_ff[IW-1:0]];
      end
      // result register
      if (state_ff == ST_IS_EMIT) begin
         rsp_kind <= KIND_INIT_WRITE;
         rsp_var_index <= cur_ff;
         rsp_next_node <= $signed({5'b0, step_nxt}) + 9'(offset_ff);
         rsp_steps_left <= (pos_ff < count_ff) ? count_ff - pos_ff : CW'(0);
         rsp_last <= 1'b1;
      end else begin
         rsp_kind <= r_kind;
         rsp_var_index <= r_var;
         rsp_next_node <= r_zero ? 9'sd0 : $signed({5'b0, r_nxt}) + 9'(offset_ff);
         rsp_steps_left <= r_steps;
         rsp_last <= r_last;
      end
   end

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == OP_MOVE || req_op == OP_INIT_BEGIN)) |=> busy)
      else $error("busy not raised");
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> pos_ff <= count_ff)
      else $error("step position beyond free count");
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("busy after last beat");
endmodule
